FILE: design/mipd_pkg.sv
// Package for the minimum-image pair distance block.
// Holds shared widths, config register indexes and the front-to-back word type.
package mipd_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int BOX_W           = 31;
	localparam int CFG_IDX_W       = 2;
	localparam int DATA_W          = 32;
	localparam int OUT_W           = 50;
	localparam int TERM_W          = 33;   // folded per-axis magnitude
	localparam int SQ_W            = 66;   // sum of three squares
	localparam int ROOT_W          = 34;   // floor sqrt of the sum
	localparam int QUEUE_DEPTH     = 4;
	localparam int QUEUE_AW        = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 2'd2;

	typedef struct packed {
		logic              mode;
		logic [TERM_W-1:0] tx;
		logic [TERM_W-1:0] ty;
		logic [TERM_W-1:0] tz;
	} mipd_word_t;

endpackage

FILE: design/min_image_pair_distance_top.sv
// Minimum-image pair distance top level. Depends on mipd_pkg, mipd_front,
// mipd_queue and mipd_back.
//
// One word per cycle in and out while the output is not held. A word accepted
// passes through capture and per-axis fold in the front, the queue write,
// products, squares and sum, the root pipe load and its 34 one-bit stages, and
// the output register before it shows on dist_value. Mode 0 words ride the root
// pipe unchanged, so both modes take the same time. The input stalls once a held
// output has halted the whole back pipe, the 4-word queue is full and a word
// waits at the front output. Box widths must be written by the user through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// Mode 0 yields Q34.16 squared distance, mode 1 the Q18.16 floor distance.
module min_image_pair_distance_top import mipd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [BOX_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   mode,
	input  logic [COORD_WIDTH-1:0] ax,
	input  logic [COORD_WIDTH-1:0] ay,
	input  logic [COORD_WIDTH-1:0] az,
	input  logic [COORD_WIDTH-1:0] bx,
	input  logic [COORD_WIDTH-1:0] by,
	input  logic [COORD_WIDTH-1:0] bz,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_W-1:0]       dist_value
);

	logic [BOX_W-1:0] wx_q, wy_q, wz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_q <= '0; wy_q <= '0; wz_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_X: wx_q <= cfg_data;
				REG_BOX_Y: wy_q <= cfg_data;
				REG_BOX_Z: wz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic       f_valid, f_take, q_ne, q_nf, b_take;
	mipd_word_t f_word, q_head;

	// front words move only when the queue has room
	assign f_take   = f_valid && q_nf;
	assign in_stall = f_valid && !q_nf;

	mipd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk, .arst_n,
		.in_take(in_valid && !in_stall),
		.mode, .ax, .ay, .az, .bx, .by, .bz,
		.wx(wx_q), .wy(wy_q), .wz(wz_q),
		.out_take(f_take), .out_valid(f_valid), .out_word(f_word)
	);

	mipd_queue u_queue (
		.clk, .arst_n,
		.push(f_take), .push_word(f_word),
		.pop(b_take), .not_empty(q_ne), .not_full(q_nf), .head(q_head)
	);

	mipd_back u_back (
		.clk, .arst_n,
		.in_valid(q_ne), .in_word(q_head), .in_take(b_take),
		.out_valid, .out_stall, .out_value(dist_value)
	);

endmodule

FILE: design/mipd_front.sv
// Front part: latches the input word and folds the three axes.
// Depends on mipd_pkg.
module mipd_front import mipd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_take,
	input  logic                   mode,
	input  logic [COORD_WIDTH-1:0] ax,
	input  logic [COORD_WIDTH-1:0] ay,
	input  logic [COORD_WIDTH-1:0] az,
	input  logic [COORD_WIDTH-1:0] bx,
	input  logic [COORD_WIDTH-1:0] by,
	input  logic [COORD_WIDTH-1:0] bz,
	input  logic [BOX_W-1:0]       wx,
	input  logic [BOX_W-1:0]       wy,
	input  logic [BOX_W-1:0]       wz,
	input  logic                   out_take,
	output logic                   out_valid,
	output mipd_word_t             out_word
);

	function automatic logic [TERM_W-1:0] fold(
		input logic [COORD_WIDTH-1:0] a,
		input logic [COORD_WIDTH-1:0] b,
		input logic [BOX_W-1:0] w
	);
		logic signed [TERM_W:0] diff;
		logic [TERM_W-1:0] mag;
		logic signed [TERM_W+1:0] f;
		begin
			diff = (TERM_W+1)'($signed(a)) - (TERM_W+1)'($signed(b));
			mag  = diff[TERM_W] ? TERM_W'(-diff) : diff[TERM_W-1:0];
			if ({mag, 1'b0} > {3'b0, w}) begin
				f = $signed({3'b0, w}) - $signed({2'b0, mag});
				fold = f[TERM_W+1] ? TERM_W'(-f) : f[TERM_W-1:0];
			end else begin
				fold = mag;
			end
		end
	endfunction

	logic                   valid_s1;
	logic                   mode_s1;
	logic [COORD_WIDTH-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;

	// stage 1: capture; stage 2: fold result register
	logic s1_move;
	assign s1_move = !out_valid || out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s1_move) out_valid <= valid_s1;
			if (s1_move || !valid_s1) valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1 <= mode;
			ax_s1 <= ax; ay_s1 <= ay; az_s1 <= az;
			bx_s1 <= bx; by_s1 <= by; bz_s1 <= bz;
		end
		if (s1_move && valid_s1) begin
			out_word.mode <= mode_s1;
			out_word.tx   <= fold(ax_s1, bx_s1, wx);
			out_word.ty   <= fold(ay_s1, by_s1, wy);
			out_word.tz   <= fold(az_s1, bz_s1, wz);
		end
	end

endmodule

FILE: design/mipd_queue.sv
// Short queue between front and back parts.
// Depends on mipd_pkg.
module mipd_queue import mipd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mipd_word_t push_word,
	input  logic       pop,
	output logic       not_empty,
	output logic       not_full,
	output mipd_word_t head
);

	mipd_word_t            mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_q, rd_q;
	logic [QUEUE_AW:0]     cnt_q;

	assign not_empty = cnt_q != '0;
	assign not_full  = cnt_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign head      = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_word;
	end

endmodule

FILE: design/mipd_back.sv
// Back part: squares, sums, then shifts or takes a pipelined square root.
// Depends on mipd_pkg.
module mipd_back import mipd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  mipd_word_t       in_word,
	output logic             in_take,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [OUT_W-1:0] out_value
);

	// stage A: 17x17 partial products of each square (one mult each, <= 34-bit)
	// stage B: squares; stage C: sum; root load plus ROOT_W sqrt stages; then output
	localparam int NST = ROOT_W + 5;

	logic adv;
	logic [NST-1:0] v_q;
	assign adv     = !v_q[NST-1] || !out_stall;
	assign in_take = adv && in_valid;
	assign out_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NST-2:0], in_valid};
	end

	// partial products per axis: hi*hi, hi*lo, lo*lo with 17-bit halves
	logic        mode_s1;
	logic [33:0] phh_s1 [3], phl_s1 [3], pll_s1 [3];
	logic        mode_s2;
	logic [SQ_W-1:0] sq_s2 [3];
	logic        mode_s3;
	logic [SQ_W-1:0] sum_s3;

	logic [TERM_W-1:0] t [3];
	assign t[0] = in_word.tx;
	assign t[1] = in_word.ty;
	assign t[2] = in_word.tz;

	// sqrt pipeline: remainder/root restoring, one bit per stage
	logic [ROOT_W-1:0] root_q [ROOT_W+1];
	logic [SQ_W-1:0]   rem_q  [ROOT_W+1];
	logic              md_q   [ROOT_W+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= in_word.mode;
			for (int i = 0; i < 3; i++) begin
				phh_s1[i] <= 34'({1'b0, t[i][32:17]}) * 34'({1'b0, t[i][32:17]});
				phl_s1[i] <= 34'({1'b0, t[i][32:17]}) * 34'(t[i][16:0]);
				pll_s1[i] <= 34'(t[i][16:0]) * 34'(t[i][16:0]);
			end
			mode_s2 <= mode_s1;
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= (SQ_W'(phh_s1[i]) << 34) + (SQ_W'(phl_s1[i]) << 18)
					+ SQ_W'(pll_s1[i]);
			mode_s3 <= mode_s2;
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			root_q[0] <= '0;
			rem_q[0]  <= sum_s3;
			md_q[0]   <= mode_s3;
			for (int k = 0; k < ROOT_W; k++) begin
				// keep mode-0 sum in rem when mode is 0: skip updates
				// (r + 2^b)^2 - r^2 = (r << (b+1)) + 2^(2b)
				logic [SQ_W+1:0] trial;
				trial = ((SQ_W+2)'(root_q[k]) << (ROOT_W - k))
					+ ((SQ_W+2)'(1) << (2 * (ROOT_W - 1 - k)));
				md_q[k+1] <= md_q[k];
				if (md_q[k] && trial <= (SQ_W+2)'(rem_q[k])) begin
					root_q[k+1] <= root_q[k] | (ROOT_W'(1) << (ROOT_W-1-k));
					rem_q[k+1]  <= rem_q[k] - trial[SQ_W-1:0];
				end else begin
					root_q[k+1] <= root_q[k];
					rem_q[k+1]  <= rem_q[k];
				end
			end
			out_value <= md_q[ROOT_W] ? OUT_W'(root_q[ROOT_W])
				: rem_q[ROOT_W][OUT_W+15:16];
		end
	end

endmodule
